### rtl/core/wsp_pkg.sv
// Shared constants and types of the WAV stream parser.
`default_nettype none

package wsp_pkg;

    // Status codes reported on the result for the final file byte
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_BADTAG = 3'd2;
    localparam logic [2:0] ST_TRUNC  = 3'd3;
    localparam logic [2:0] ST_NODATA = 3'd4;
    localparam logic [2:0] ST_FORMAT = 3'd5;
    localparam logic [2:0] ST_EMPTY  = 3'd6;
    localparam logic [2:0] ST_BRIEF  = 3'd7;

    // Chunk ids as read little-endian from the header
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [4:0]  FMT_MIN_BYTES    = 5'd16;
    localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
    localparam logic [31:0] DEFAULT_RATE     = 32'd22050;
    localparam logic [15:0] DEFAULT_BITS     = 16'd16;
    localparam logic [15:0] PCM_BITS         = 16'd16;

    typedef struct packed {
        logic [7:0]  sample_byte;
        logic        is_sample;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } result_t;

    // Parse stage output: result plus a flag that asks for the duration test
    typedef struct packed {
        result_t res;
        logic    brief_check;
    } stage_t;

endpackage

`default_nettype wire

### rtl/core/wsp_byte_if.sv
// Input byte channel of the WAV stream parser.
`default_nettype none

interface wsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/wsp_result_if.sv
// Result channel of the WAV stream parser.
`default_nettype none

interface wsp_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sample_byte;
    logic        is_sample;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;

    modport source (output valid, output sample_byte, output is_sample, output done_res,
                    output status, output channel_count, output sample_rate,
                    output sample_bits, output data_length, input ready);
    modport sink   (input valid, input sample_byte, input is_sample, input done_res,
                    input status, input channel_count, input sample_rate,
                    input sample_bits, input data_length, output ready);
endinterface

`default_nettype wire

### rtl/core/wav_stream_parser.sv
// Top level of the WAV stream parser: byte channel in, result channel out.
//
// Usage:
//   byte_in carries a WAV file one byte per item; final_byte marks its last
//   byte. result_out carries one item for each data chunk byte that passes
//   through and one for the final byte (both in one item when they coincide).
//   The item for the final byte has done_res set and a valid status; every
//   item shows the format fields and data byte count captured so far.
// Pipeline: a result passes the input register, parse register, product
//   register and output register after its byte is accepted.
// Throughput: one byte per cycle while the pipeline is not stalled, bound
//   by the chunk walker whose state updates once per byte.
// Reset: parser state returns to the start of a file (tag check, default
//   format of 1 channel, 22050 Hz, 16 bits); the pipeline empties. The same
//   return to defaults happens after each final byte, so files may follow
//   back to back.
// Stall: while a result waits and result_out.ready is low, the whole
//   pipeline holds and byte_in.ready drops; nothing is lost or repeated.
`default_nettype none

module wav_stream_parser #(
    parameter int MIN_FILE_BYTES = 44
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wsp_byte_if.sink      byte_in,
    wsp_result_if.source  result_out
);

    logic             en;
    logic             s1_valid;
    wsp_pkg::stage_t  s1;
    logic             out_valid;
    wsp_pkg::result_t out_res;

    // Advance every stage when the output register is free or being taken
    assign en = !out_valid || result_out.ready;
    assign byte_in.ready = en;

    wsp_parse #(
        .MIN_FILE_BYTES (MIN_FILE_BYTES)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (byte_in.valid),
        .in_byte  (byte_in.byte_value),
        .in_final (byte_in.final_byte),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    wsp_status u_status (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign result_out.valid         = out_valid;
    assign result_out.sample_byte   = out_res.sample_byte;
    assign result_out.is_sample     = out_res.is_sample;
    assign result_out.done_res      = out_res.done_res;
    assign result_out.status        = out_res.status;
    assign result_out.channel_count = out_res.channel_count;
    assign result_out.sample_rate   = out_res.sample_rate;
    assign result_out.sample_bits   = out_res.sample_bits;
    assign result_out.data_length   = out_res.data_length;

    // Every result carries a data byte or closes a file
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_res.is_sample || out_res.done_res))
        else $error("result item with neither sample nor done");

    // Status only on the closing item
    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_res.done_res) |-> (out_res.status == wsp_pkg::ST_OK))
        else $error("status set on a non-final item");

    // An OK file has a supported format and at least one data byte
    a_ok_means_pcm16: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.done_res && out_res.status == wsp_pkg::ST_OK) |->
        (out_res.sample_bits == wsp_pkg::PCM_BITS && out_res.channel_count != 16'd0 &&
         out_res.data_length != 32'd0))
        else $error("OK status with unsupported format or no data");

    // Non-sample items carry a zero byte
    a_zero_non_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_res.is_sample) |-> (out_res.sample_byte == 8'd0))
        else $error("non-sample item carries a byte");

endmodule

`default_nettype wire

### rtl/core/wsp_parse.sv
// Input register, RIFF chunk walker and parse result register.
`default_nettype none

module wsp_parse #(
    parameter int MIN_FILE_BYTES = 44
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_final,
    output logic                s1_valid,
    output wsp_pkg::stage_t     s1
);

    localparam int CNT_W = $clog2(MIN_FILE_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MIN_FILE_BYTES);
    localparam logic [CNT_W-1:0] TAG_END = CNT_W'(12);
    localparam logic [CNT_W-1:0] TAG_LAST = CNT_W'(11);
    localparam logic [CNT_W-1:0] SIZE_LO = CNT_W'(4);
    localparam logic [CNT_W-1:0] SIZE_HI = CNT_W'(8);

    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SINK = 3'd5;

    function automatic logic [7:0] tag_byte(input logic [3:0] idx);
        logic [7:0] t;
        case (idx)
            4'd0:    t = 8'h52;  // R
            4'd1:    t = 8'h49;  // I
            4'd2:    t = 8'h46;  // F
            4'd3:    t = 8'h46;  // F
            4'd8:    t = 8'h57;  // W
            4'd9:    t = 8'h41;  // A
            4'd10:   t = 8'h56;  // V
            4'd11:   t = 8'h45;  // E
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    // input register
    logic            s0_valid_reg;
    logic [7:0]      s0_byte_reg;
    logic            s0_final_reg;

    // parser state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       phase_reg, phase_next;
    logic [63:0]      hdr_reg, hdr_next;
    logic [32:0]      remain_reg, remain_next;
    logic [4:0]       off_reg, off_next;
    logic [15:0]      chan_reg, chan_next;
    logic [31:0]      rate_reg, rate_next;
    logic [15:0]      bits_reg, bits_next;
    logic [31:0]      copied_reg, copied_next;
    logic [2:0]       err_reg, err_next;
    logic             seen_reg, seen_next;

    logic             s1_valid_reg;
    wsp_pkg::stage_t  s1_reg, s1_next;

    logic [63:0] hdr_shifted;
    logic [32:0] size_ext, size_padded, remain_dec;
    logic [4:0]  off_inc;
    logic        sample;
    logic        is_short, is_trunc, fmt_bad;
    logic [2:0]  pre_status;

    always_comb
    begin
        cnt_next    = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        remain_next = remain_reg;
        off_next    = off_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        copied_next = copied_reg;
        err_next    = err_reg;
        seen_next   = seen_reg;
        sample      = 1'b0;

        hdr_shifted = {s0_byte_reg, hdr_reg[63:8]};
        size_ext    = {1'b0, hdr_shifted[63:32]};
        size_padded = size_ext + {32'd0, size_ext[0]};
        remain_dec  = (remain_reg != 33'd0) ? remain_reg - 33'd1 : remain_reg;
        off_inc     = off_reg + 5'd1;

        case (phase_reg)
            PH_TAG:
            begin
                if (cnt_reg < TAG_END && (cnt_reg < SIZE_LO || cnt_reg >= SIZE_HI) &&
                    s0_byte_reg != tag_byte(cnt_reg[3:0]) && err_reg == wsp_pkg::ST_OK)
                begin
                    err_next = wsp_pkg::ST_BADTAG;
                end
                if (cnt_reg >= TAG_LAST)
                begin
                    phase_next = (err_next != wsp_pkg::ST_OK) ? PH_SINK : PH_HDR;
                    off_next   = 5'd0;
                    hdr_next   = 64'd0;
                end
            end
            PH_HDR:
            begin
                hdr_next = hdr_shifted;
                off_next = off_inc;
                if (off_inc >= 5'd8)
                begin
                    off_next = 5'd0;
                    if (hdr_shifted[31:0] == wsp_pkg::ID_FMT)
                    begin
                        if (size_ext < 33'(wsp_pkg::FMT_MIN_BYTES))
                        begin
                            if (err_reg == wsp_pkg::ST_OK)
                            begin
                                err_next = wsp_pkg::ST_TRUNC;
                            end
                            phase_next = PH_SINK;
                        end
                        else
                        begin
                            remain_next = size_padded;
                            phase_next  = PH_FMT;
                        end
                    end
                    else if (hdr_shifted[31:0] == wsp_pkg::ID_DATA)
                    begin
                        seen_next   = 1'b1;
                        remain_next = size_ext;
                        phase_next  = (size_ext == 33'd0) ? PH_SINK : PH_DATA;
                    end
                    else
                    begin
                        remain_next = size_padded;
                        phase_next  = (size_padded == 33'd0) ? PH_HDR : PH_SKIP;
                    end
                end
            end
            PH_FMT:
            begin
                if (off_reg < wsp_pkg::FMT_MIN_BYTES)
                begin
                    case (off_reg)
                        5'd2:    chan_next[7:0]   = s0_byte_reg;
                        5'd3:    chan_next[15:8]  = s0_byte_reg;
                        5'd4:    rate_next[7:0]   = s0_byte_reg;
                        5'd5:    rate_next[15:8]  = s0_byte_reg;
                        5'd6:    rate_next[23:16] = s0_byte_reg;
                        5'd7:    rate_next[31:24] = s0_byte_reg;
                        5'd14:   bits_next[7:0]   = s0_byte_reg;
                        5'd15:   bits_next[15:8]  = s0_byte_reg;
                        default: ;
                    endcase
                    off_next = off_inc;
                end
                remain_next = remain_dec;
                if (remain_dec == 33'd0)
                begin
                    phase_next = PH_HDR;
                    off_next   = 5'd0;
                end
            end
            PH_SKIP:
            begin
                remain_next = remain_dec;
                if (remain_dec == 33'd0)
                begin
                    phase_next = PH_HDR;
                    off_next   = 5'd0;
                end
            end
            PH_DATA:
            begin
                sample      = 1'b1;
                copied_next = copied_reg + 32'd1;
                remain_next = remain_dec;
                if (remain_dec == 33'd0)
                begin
                    phase_next = PH_SINK;
                end
            end
            default: ;
        endcase

        // Status classes ahead of the duration test, on the updated state
        is_short = cnt_next < CNT_SAT;
        is_trunc = phase_next == PH_FMT && off_next < wsp_pkg::FMT_MIN_BYTES;
        fmt_bad  = bits_next != wsp_pkg::PCM_BITS || chan_next == 16'd0 ||
                   rate_next == 32'd0 || rate_next[31];
        if (is_short)
            pre_status = wsp_pkg::ST_SHORT;
        else if (err_next != wsp_pkg::ST_OK)
            pre_status = err_next;
        else if (is_trunc)
            pre_status = wsp_pkg::ST_TRUNC;
        else if (!seen_next)
            pre_status = wsp_pkg::ST_NODATA;
        else if (fmt_bad)
            pre_status = wsp_pkg::ST_FORMAT;
        else if (copied_next == 32'd0)
            pre_status = wsp_pkg::ST_EMPTY;
        else
            pre_status = wsp_pkg::ST_OK;

        s1_next.res.sample_byte   = sample ? s0_byte_reg : 8'd0;
        s1_next.res.is_sample     = sample;
        s1_next.res.done_res      = s0_final_reg;
        s1_next.res.status        = s0_final_reg ? pre_status : wsp_pkg::ST_OK;
        s1_next.res.channel_count = chan_next;
        s1_next.res.sample_rate   = rate_next;
        s1_next.res.sample_bits   = bits_next;
        s1_next.res.data_length   = copied_next;
        s1_next.brief_check       = s0_final_reg && pre_status == wsp_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg && (sample || s0_final_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_byte_reg  <= in_byte;
            s0_final_reg <= in_final;
            s1_reg       <= s1_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            phase_reg  <= PH_TAG;
            hdr_reg    <= 64'd0;
            remain_reg <= 33'd0;
            off_reg    <= 5'd0;
            chan_reg   <= wsp_pkg::DEFAULT_CHANNELS;
            rate_reg   <= wsp_pkg::DEFAULT_RATE;
            bits_reg   <= wsp_pkg::DEFAULT_BITS;
            copied_reg <= 32'd0;
            err_reg    <= wsp_pkg::ST_OK;
            seen_reg   <= 1'b0;
        end
        else if (en && s0_valid_reg)
        begin
            if (s0_final_reg)
            begin
                // end of file: start over for the next file
                cnt_reg    <= '0;
                phase_reg  <= PH_TAG;
                hdr_reg    <= 64'd0;
                remain_reg <= 33'd0;
                off_reg    <= 5'd0;
                chan_reg   <= wsp_pkg::DEFAULT_CHANNELS;
                rate_reg   <= wsp_pkg::DEFAULT_RATE;
                bits_reg   <= wsp_pkg::DEFAULT_BITS;
                copied_reg <= 32'd0;
                err_reg    <= wsp_pkg::ST_OK;
                seen_reg   <= 1'b0;
            end
            else
            begin
                cnt_reg    <= cnt_next;
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                remain_reg <= remain_next;
                off_reg    <= off_next;
                chan_reg   <= chan_next;
                rate_reg   <= rate_next;
                bits_reg   <= bits_next;
                copied_reg <= copied_next;
                err_reg    <= err_next;
                seen_reg   <= seen_next;
            end
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

`default_nettype wire

### rtl/core/wsp_status.sv
// Duration test: product stage and output register.
`default_nettype none

module wsp_status (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            s1_valid,
    input  wire wsp_pkg::stage_t s1,
    output logic                 out_valid,
    output wsp_pkg::result_t     out_res
);

    logic             s2_valid_reg;
    wsp_pkg::stage_t  s2_reg;
    logic [37:0]      lhs_reg, lhs_next;   // copied bytes * 50
    logic [47:0]      rhs_reg, rhs_next;   // rate * channels
    logic             out_valid_reg;
    wsp_pkg::result_t out_reg, out_next;
    logic [37:0]      copied_ext;

    always_comb
    begin
        copied_ext = {6'd0, s1.res.data_length};
        lhs_next   = (copied_ext << 5) + (copied_ext << 4) + (copied_ext << 1);
        rhs_next   = {16'd0, s1.res.sample_rate} * {32'd0, s1.res.channel_count};

        out_next = s2_reg.res;
        if (s2_reg.brief_check)
        begin
            out_next.status = ({10'd0, lhs_reg} <= rhs_reg) ? wsp_pkg::ST_BRIEF
                                                            : wsp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg  <= s1;
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire
